FILE: design/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg: shared definitions for the direct-mapped tag lookup
// Widths, register indexes, reset values and the tag store line format.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int DMC_MAX_LINES  = 1024;
  localparam int DMC_ADDR_WIDTH = 32;

  localparam int WORD_W  = 32;
  localparam int TAG_W   = 32;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CNT_W   = 32;

  // masked index before folding onto the store: ib <= 15
  localparam int RAW_IDX_W = 16;
  localparam int SHAMT_W   = 5;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd2;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd10;
  localparam logic [CNT_W-1:0] CNT_MAX         = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 4'd0,
    CFG_INDEX_BITS  = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } line_t;

endpackage

FILE: design/dmc_addr_split.sv
// ----------------------------------------------------------------------------
// dmc_addr_split: word address to line index and tag
// Skips offset bits, masks to index bits, folds onto the store depth.
// ----------------------------------------------------------------------------
module dmc_addr_split import dmc_pkg::*; #(
  parameter int MAX_LINES  = DMC_MAX_LINES,
  parameter int ADDR_WIDTH = DMC_ADDR_WIDTH,
  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic [WORD_W-1:0] addr_i,
  input  logic [CFG_W-1:0]  offset_bits_i,
  input  logic [CFG_W-1:0]  index_bits_i,
  output logic [IDX_W-1:0]  idx_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam logic [WORD_W-1:0] ADDR_MASK = (ADDR_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam bit IS_POW2 = (MAX_LINES & (MAX_LINES - 1)) == 0;
  localparam int NSTEPS  = (16 - $clog2(MAX_LINES) > 0) ? (16 - $clog2(MAX_LINES)) : 1;

  logic [WORD_W-1:0]    addr;
  logic [WORD_W-1:0]    shifted;
  logic [RAW_IDX_W-1:0] idx_mask;
  logic [RAW_IDX_W-1:0] raw_idx;
  logic [SHAMT_W-1:0]   tag_shamt;

  assign addr      = addr_i & ADDR_MASK;
  assign shifted   = addr >> offset_bits_i;
  assign idx_mask  = (RAW_IDX_W'(1) << index_bits_i) - RAW_IDX_W'(1);
  assign raw_idx   = shifted[RAW_IDX_W-1:0] & idx_mask;
  assign tag_shamt = {1'b0, offset_bits_i} + {1'b0, index_bits_i};
  assign tag_o     = TAG_W'(addr >> tag_shamt);

  generate
    if (MAX_LINES == 1) begin : g_single
      assign idx_o = '0;
    end else if (IS_POW2) begin : g_pow2
      assign idx_o = raw_idx[IDX_W-1:0];
    end else begin : g_fold
      // restoring reduction by shifted copies of the depth
      always_comb begin
        logic [RAW_IDX_W-1:0] r;
        r = raw_idx;
        for (int k = NSTEPS - 1; k >= 0; k--) begin
          if ({16'd0, r} >= (32'(MAX_LINES) << k)) begin
            r = RAW_IDX_W'({16'd0, r} - (32'(MAX_LINES) << k));
          end
        end
        idx_o = r[IDX_W-1:0];
      end
    end
  endgenerate

endmodule

FILE: design/dmc_tag_store.sv
// ----------------------------------------------------------------------------
// dmc_tag_store: line memory with registered read and reset sweep
// Holds valid flag and tag per line; invalidates every line after reset.
// ----------------------------------------------------------------------------
module dmc_tag_store import dmc_pkg::*; #(
  parameter int MAX_LINES = DMC_MAX_LINES,
  localparam int IDX_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output line_t            rd_line_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  line_t            wr_line_i,
  output logic             clearing_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LINES - 1);

  line_t            mem_q [MAX_LINES];
  line_t            rd_line_q;
  logic             clr_q, clr_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic             we;
  logic [IDX_W-1:0] waddr;
  line_t            wdata;

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == LAST_IDX) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  assign we    = clr_q | wr_en_i;
  assign waddr = clr_q ? clr_idx_q : wr_idx_i;
  assign wdata = clr_q ? line_t'('0) : wr_line_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_line_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_line_o  = rd_line_q;
  assign clearing_o = clr_q;

endmodule

FILE: design/direct_mapped_cache_hit_tracker.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_tracker: direct-mapped tag lookup with hit counters
// Each accepted word is registered into s1 with its tag store read, then into
// done_q and hit_q, driving done_o and hit_o. Throughput: one word per cycle
// while busy is low. Reset: counters clear at once; busy stays high while
// every line is invalidated. The receiver cannot stall; results never wait.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_tracker import dmc_pkg::*; #(
  parameter int MAX_LINES  = DMC_MAX_LINES,
  parameter int ADDR_WIDTH = DMC_ADDR_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_W-1:0]    word_address_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [CNT_W-1:0]     hit_count_o,
  output logic [CNT_W-1:0]     miss_count_o
);

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  logic [CFG_W-1:0] offset_bits_q, index_bits_q;
  logic             accept;
  logic             clearing;
  logic [IDX_W-1:0] in_idx;
  logic [TAG_W-1:0] in_tag;

  logic             s1_valid_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [TAG_W-1:0] s1_tag_q;
  line_t            rd_line;
  line_t            cur_line;
  line_t            fill_line;
  logic             s1_hit;
  logic             miss_wr;

  logic             fwd_valid_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [TAG_W-1:0] fwd_tag_q;

  logic             done_q, hit_q;
  logic [CNT_W-1:0] hits_q, hits_d, misses_q, misses_d;

  assign cfg_ready_o = 1'b1;
  assign busy        = clearing;
  assign accept      = start & ~clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_BITS_RST;
      index_bits_q  <= INDEX_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dmc_addr_split #(
    .MAX_LINES  (MAX_LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_split (
    .addr_i        (word_address_i),
    .offset_bits_i (offset_bits_q),
    .index_bits_i  (index_bits_q),
    .idx_o         (in_idx),
    .tag_o         (in_tag)
  );

  assign fill_line = '{valid: 1'b1, tag: s1_tag_q};

  dmc_tag_store #(
    .MAX_LINES (MAX_LINES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (in_idx),
    .rd_line_o  (rd_line),
    .wr_en_i    (miss_wr),
    .wr_idx_i   (s1_idx_q),
    .wr_line_i  (fill_line),
    .clearing_o (clearing)
  );

  // the fill written at the edge this word was read is not in rd_line yet
  always_comb begin
    cur_line = rd_line;
    if (fwd_valid_q && (fwd_idx_q == s1_idx_q)) begin
      cur_line = '{valid: 1'b1, tag: fwd_tag_q};
    end
  end

  assign s1_hit  = cur_line.valid && (cur_line.tag == s1_tag_q);
  assign miss_wr = s1_valid_q & ~s1_hit;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (s1_valid_q) begin
      if (s1_hit) begin
        hits_d = (hits_q == CNT_MAX) ? hits_q : hits_q + CNT_W'(1);
      end else begin
        misses_d = (misses_q == CNT_MAX) ? misses_q : misses_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
    end else begin
      s1_valid_q  <= accept;
      fwd_valid_q <= miss_wr;
      done_q      <= s1_valid_q;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q <= in_idx;
      s1_tag_q <= in_tag;
    end
    fwd_idx_q <= s1_idx_q;
    fwd_tag_q <= s1_tag_q;
    hit_q     <= s1_hit;
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule
